// File: sv/slds_pkg.sv
// ----------------------------------------------------------------------------
// slds_pkg
// shared types and constants for the ordered record list with date sort
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slds_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned STACK_DEPTH  = 64;
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned STK_W        = 12;

  typedef enum logic [3:0] {
    ACT_INS_FRONT = 4'd0,
    ACT_INS_BACK  = 4'd1,
    ACT_INS_AT    = 4'd2,
    ACT_REM_FRONT = 4'd3,
    ACT_REM_BACK  = 4'd4,
    ACT_REM_AT    = 4'd5,
    ACT_SEARCH    = 4'd6,
    ACT_SORT      = 4'd7,
    ACT_DUMP      = 4'd8
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_POS_RANGE = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic [3:0]  action;
    logic [6:0]  position;
    logic [15:0] entry_id;
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [11:0] start_year;
    logic [31:0] payload;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_id;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [11:0] out_year;
    logic [31:0] out_payload;
    logic [5:0]  out_position;
    logic [6:0]  entry_total;
    logic        last;
  } out_word_t;

  // one stored record, date fields on top so that {year,month,day} orders by date
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] id;
    logic [31:0] payload;
  } rec_t;

endpackage

`default_nettype wire

// File: sv/sequential_list_with_date_sort_unit.sv
// insert and remove shift each entry behind the position by one place; a search reads
//   entries in order until the id matches; a dump waits out any output stall on each word; sort
//   compares, swaps and pops ranges one after another
// one action at a time; the input stalls until the result words have been taken
// reset: entry count and all control state cleared at once; record and range stack
//   memories are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
// sequential_list_with_date_sort_unit
// dense ordered record list in a synchronous memory, with in-place date quicksort
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sequential_list_with_date_sort_unit #(
  parameter int unsigned CAPACITY = slds_pkg::CAPACITY_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire slds_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output slds_pkg::out_word_t      out_word_o
);

  localparam int unsigned AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = slds_pkg::CNT_W;
  localparam int unsigned IW  = slds_pkg::IDX_W;
  localparam int unsigned SAW = $clog2(slds_pkg::STACK_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE, S_INS_RD, S_INS_WR, S_INS_PUT,
    S_REM_RD, S_REM_CAP, S_REM_SH_RD, S_REM_SH_WR,
    S_SRCH_RD, S_SRCH_CHK, S_DMP_RD, S_DMP_CAP,
    S_SRT_POP, S_SRT_POP2, S_SRT_PIV_RD, S_SRT_PIV, S_SRT_LOOP,
    S_SRT_I_RD, S_SRT_I_CHK, S_SRT_J_RD, S_SRT_J_CHK, S_SRT_SW_CHK,
    S_SRT_SW_RI, S_SRT_SW_RJ, S_SRT_SW_WI, S_SRT_SW_WJ,
    S_SRT_PUSH_A, S_SRT_PUSH_B, S_WAIT
  } state_e;

  // record memory and range stack
  slds_pkg::rec_t             rec_mem [CAPACITY];
  logic [slds_pkg::STK_W-1:0] stk_mem [slds_pkg::STACK_DEPTH];

  state_e                     state_q;
  slds_pkg::in_word_t         act_q;
  logic [CW-1:0]              cnt_q;
  logic [CW-1:0]              idx_q;
  logic [CW-1:0]              pos_q;
  logic [CW-1:0]              sp_q;
  logic [IW-1:0]              lo_q, hi_q;
  logic signed [7:0]          i_q, j_q;
  logic [20:0]                pivot_q;
  slds_pkg::rec_t             rec_q;
  slds_pkg::rec_t             rd_q;
  logic [slds_pkg::STK_W-1:0] srd_q;
  slds_pkg::out_word_t        out_q;
  logic                       out_valid_q;
  logic                       more_q;

  // memory port controls
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  slds_pkg::rec_t             mem_wdata;
  logic                       stk_we;
  logic [SAW-1:0]             stk_waddr, stk_raddr;
  logic [slds_pkg::STK_W-1:0] stk_wdata;

  logic [CW-1:0]              idx_m1, idx_p1, ins_pos, rem_pos, cnt_m1, sp_m1;
  logic [IW:0]                piv_sum;
  logic [IW-1:0]              piv_mid;
  logic [20:0]                rd_date;
  logic                       i_lt_hi, j_gt_lo, i_le_j, lo_lt_j, sp_room;
  slds_pkg::rec_t             new_rec;
  slds_pkg::out_word_t        idle_word, dmp_word;
  logic                       out_take;

  assign idx_m1   = idx_q - CW'(1);
  assign idx_p1   = idx_q + CW'(1);
  assign cnt_m1   = cnt_q - CW'(1);
  assign sp_m1    = sp_q - CW'(1);
  assign piv_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign piv_mid  = piv_sum[IW:1];
  assign rd_date  = {rd_q.year, rd_q.month, rd_q.day};
  assign i_lt_hi  = i_q < $signed({2'b00, hi_q});
  assign j_gt_lo  = j_q > $signed({2'b00, lo_q});
  assign i_le_j   = i_q <= j_q;
  assign lo_lt_j  = $signed({2'b00, lo_q}) < j_q;
  assign sp_room  = sp_q < CW'(slds_pkg::STACK_DEPTH);
  assign out_take = out_valid_q && !out_stall_i;

  assign new_rec = '{year: act_q.start_year, month: act_q.start_month,
                     day: act_q.start_day, id: act_q.entry_id,
                     payload: act_q.payload};

  // position each kind of insert or remove works at
  always_comb begin
    case (slds_pkg::action_e'(in_word_i.action))
      slds_pkg::ACT_INS_FRONT: ins_pos = '0;
      slds_pkg::ACT_INS_BACK:  ins_pos = cnt_q;
      default:                 ins_pos = in_word_i.position;
    endcase
    case (slds_pkg::action_e'(in_word_i.action))
      slds_pkg::ACT_REM_FRONT: rem_pos = '0;
      slds_pkg::ACT_REM_BACK:  rem_pos = cnt_m1;
      default:                 rem_pos = in_word_i.position;
    endcase
  end

  // word loaded on accept: status of an action that cannot be done, else ok
  always_comb begin
    idle_word             = '0;
    idle_word.entry_total = cnt_q;
    idle_word.last        = 1'b1;
    case (slds_pkg::action_e'(in_word_i.action)) inside
      slds_pkg::ACT_INS_FRONT, slds_pkg::ACT_INS_BACK, slds_pkg::ACT_INS_AT: begin
        if (cnt_q >= CW'(CAPACITY)) begin
          idle_word.status = slds_pkg::ST_FULL;
        end else if (ins_pos > cnt_q) begin
          idle_word.status = slds_pkg::ST_POS_RANGE;
        end
      end
      slds_pkg::ACT_REM_FRONT, slds_pkg::ACT_REM_BACK, slds_pkg::ACT_REM_AT: begin
        if (cnt_q == '0) begin
          idle_word.status = slds_pkg::ST_EMPTY;
        end else if (rem_pos >= cnt_q) begin
          idle_word.status = slds_pkg::ST_POS_RANGE;
        end
      end
      slds_pkg::ACT_SEARCH: begin
        if (cnt_q == '0) begin
          idle_word.status = slds_pkg::ST_NOT_FOUND;
        end
      end
      slds_pkg::ACT_DUMP: begin
        if (cnt_q == '0) begin
          idle_word.status = slds_pkg::ST_EMPTY;
        end
      end
      default: ;
    endcase
  end

  // one dumped record
  always_comb begin
    dmp_word              = '0;
    dmp_word.out_id       = rd_q.id;
    dmp_word.out_day      = rd_q.day;
    dmp_word.out_month    = rd_q.month;
    dmp_word.out_year     = rd_q.year;
    dmp_word.out_payload  = rd_q.payload;
    dmp_word.out_position = idx_q[IW-1:0];
    dmp_word.entry_total  = cnt_q;
    dmp_word.last         = (idx_p1 == cnt_q);
  end

  // record memory address and write selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q[AW-1:0];
    mem_wdata = rd_q;
    mem_raddr = idx_q[AW-1:0];
    unique case (state_q)
      S_INS_RD:     mem_raddr = idx_m1[AW-1:0];
      S_INS_WR:     mem_we = 1'b1;
      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[AW-1:0];
        mem_wdata = new_rec;
      end
      S_REM_SH_RD:  mem_raddr = idx_p1[AW-1:0];
      S_REM_SH_WR:  mem_we = 1'b1;
      S_SRT_PIV_RD: mem_raddr = piv_mid[AW-1:0];
      S_SRT_I_RD,
      S_SRT_SW_RI:  mem_raddr = i_q[AW-1:0];
      S_SRT_J_RD,
      S_SRT_SW_RJ:  mem_raddr = j_q[AW-1:0];
      S_SRT_SW_WI: begin
        mem_we    = 1'b1;
        mem_waddr = i_q[AW-1:0];
      end
      S_SRT_SW_WJ: begin
        mem_we    = 1'b1;
        mem_waddr = j_q[AW-1:0];
        mem_wdata = rec_q;
      end
      default: ;
    endcase
  end

  // range stack controls
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = sp_q[SAW-1:0];
    stk_wdata = {i_q[IW-1:0], hi_q};
    stk_raddr = idx_m1[SAW-1:0];
    unique case (state_q)
      S_IDLE: begin
        // seed the whole list as the first range
        stk_we    = in_valid_i &&
                    (slds_pkg::action_e'(in_word_i.action) == slds_pkg::ACT_SORT) &&
                    (cnt_q >= CW'(2));
        stk_waddr = '0;
        stk_wdata = {IW'(0), cnt_m1[IW-1:0]};
      end
      S_SRT_POP:    stk_raddr = sp_m1[SAW-1:0];
      S_SRT_PUSH_A: stk_we = i_lt_hi && sp_room;
      S_SRT_PUSH_B: begin
        stk_we    = lo_lt_j && sp_room;
        stk_wdata = {lo_q, j_q[IW-1:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rec_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= rec_mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    srd_q <= stk_mem[stk_raddr];
  end

  // controller: state, indices, and the output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      more_q      <= 1'b0;
      idx_q       <= '0;
      pos_q       <= '0;
      sp_q        <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      pivot_q     <= '0;
      rec_q       <= '0;
      act_q       <= '0;
      out_q       <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            act_q  <= in_word_i;
            out_q  <= idle_word;
            more_q <= 1'b0;
            case (slds_pkg::action_e'(in_word_i.action)) inside
              slds_pkg::ACT_INS_FRONT, slds_pkg::ACT_INS_BACK, slds_pkg::ACT_INS_AT: begin
                if ((cnt_q >= CW'(CAPACITY)) || (ins_pos > cnt_q)) begin
                  out_valid_q <= 1'b1;
                  state_q     <= S_WAIT;
                end else begin
                  idx_q   <= cnt_q;
                  pos_q   <= ins_pos;
                  state_q <= (ins_pos == cnt_q) ? S_INS_PUT : S_INS_RD;
                end
              end
              slds_pkg::ACT_REM_FRONT, slds_pkg::ACT_REM_BACK, slds_pkg::ACT_REM_AT: begin
                if ((cnt_q == '0) || (rem_pos >= cnt_q)) begin
                  out_valid_q <= 1'b1;
                  state_q     <= S_WAIT;
                end else begin
                  idx_q   <= rem_pos;
                  state_q <= S_REM_RD;
                end
              end
              slds_pkg::ACT_SEARCH: begin
                idx_q <= '0;
                if (cnt_q == '0) begin
                  out_valid_q <= 1'b1;
                  state_q     <= S_WAIT;
                end else begin
                  state_q <= S_SRCH_RD;
                end
              end
              slds_pkg::ACT_SORT: begin
                if (cnt_q < CW'(2)) begin
                  out_valid_q <= 1'b1;
                  state_q     <= S_WAIT;
                end else begin
                  sp_q    <= CW'(1);
                  state_q <= S_SRT_POP;
                end
              end
              slds_pkg::ACT_DUMP: begin
                idx_q <= '0;
                if (cnt_q == '0) begin
                  out_valid_q <= 1'b1;
                  state_q     <= S_WAIT;
                end else begin
                  state_q <= S_DMP_RD;
                end
              end
              default: begin
                // unused codes answer ok and touch nothing
                out_valid_q <= 1'b1;
                state_q     <= S_WAIT;
              end
            endcase
          end
        end

        // open a gap by moving entries up, last one first
        S_INS_RD: state_q <= S_INS_WR;
        S_INS_WR: begin
          idx_q   <= idx_m1;
          state_q <= (idx_m1 == pos_q) ? S_INS_PUT : S_INS_RD;
        end
        S_INS_PUT: begin
          cnt_q             <= cnt_q + CW'(1);
          out_q.entry_total <= cnt_q + CW'(1);
          out_valid_q       <= 1'b1;
          state_q           <= S_WAIT;
        end

        // capture the removed record, then close the gap
        S_REM_RD: state_q <= S_REM_CAP;
        S_REM_CAP: begin
          out_q.out_id      <= rd_q.id;
          out_q.out_day     <= rd_q.day;
          out_q.out_month   <= rd_q.month;
          out_q.out_year    <= rd_q.year;
          out_q.out_payload <= rd_q.payload;
          out_q.entry_total <= cnt_q - CW'(1);
          cnt_q             <= cnt_q - CW'(1);
          if (idx_p1 < cnt_q) begin
            state_q <= S_REM_SH_RD;
          end else begin
            out_valid_q <= 1'b1;
            state_q     <= S_WAIT;
          end
        end
        S_REM_SH_RD: state_q <= S_REM_SH_WR;
        S_REM_SH_WR: begin
          idx_q <= idx_p1;
          if ((idx_p1 + CW'(1)) <= cnt_q) begin
            state_q <= S_REM_SH_RD;
          end else begin
            out_valid_q <= 1'b1;
            state_q     <= S_WAIT;
          end
        end

        S_SRCH_RD: state_q <= S_SRCH_CHK;
        S_SRCH_CHK: begin
          if (rd_q.id == act_q.entry_id) begin
            out_q.out_position <= idx_q[IW-1:0];
            out_valid_q        <= 1'b1;
            state_q            <= S_WAIT;
          end else if (idx_p1 < cnt_q) begin
            idx_q   <= idx_p1;
            state_q <= S_SRCH_RD;
          end else begin
            out_q.status <= slds_pkg::ST_NOT_FOUND;
            out_valid_q  <= 1'b1;
            state_q      <= S_WAIT;
          end
        end

        S_DMP_RD: state_q <= S_DMP_CAP;
        S_DMP_CAP: begin
          out_q       <= dmp_word;
          more_q      <= (idx_p1 != cnt_q);
          out_valid_q <= 1'b1;
          state_q     <= S_WAIT;
        end

        // quicksort: pop a range, fetch its middle pivot
        S_SRT_POP: begin
          if (sp_q == '0) begin
            out_valid_q <= 1'b1;
            state_q     <= S_WAIT;
          end else begin
            sp_q    <= sp_q - CW'(1);
            state_q <= S_SRT_POP2;
          end
        end
        S_SRT_POP2: begin
          lo_q    <= srd_q[2*IW-1:IW];
          hi_q    <= srd_q[IW-1:0];
          i_q     <= $signed({2'b00, srd_q[2*IW-1:IW]});
          j_q     <= $signed({2'b00, srd_q[IW-1:0]});
          state_q <= S_SRT_PIV_RD;
        end
        S_SRT_PIV_RD: state_q <= S_SRT_PIV;
        S_SRT_PIV: begin
          pivot_q <= rd_date;
          state_q <= S_SRT_LOOP;
        end
        S_SRT_LOOP: state_q <= i_le_j ? S_SRT_I_RD : S_SRT_PUSH_A;
        S_SRT_I_RD: state_q <= i_lt_hi ? S_SRT_I_CHK : S_SRT_J_RD;
        S_SRT_I_CHK: begin
          if (rd_date < pivot_q) begin
            i_q     <= i_q + 8'sd1;
            state_q <= S_SRT_I_RD;
          end else begin
            state_q <= S_SRT_J_RD;
          end
        end
        S_SRT_J_RD: state_q <= j_gt_lo ? S_SRT_J_CHK : S_SRT_SW_CHK;
        S_SRT_J_CHK: begin
          if (rd_date > pivot_q) begin
            j_q     <= j_q - 8'sd1;
            state_q <= S_SRT_J_RD;
          end else begin
            state_q <= S_SRT_SW_CHK;
          end
        end
        S_SRT_SW_CHK: state_q <= i_le_j ? S_SRT_SW_RI : S_SRT_PUSH_A;
        S_SRT_SW_RI:  state_q <= S_SRT_SW_RJ;
        S_SRT_SW_RJ: begin
          rec_q   <= rd_q;
          state_q <= S_SRT_SW_WI;
        end
        S_SRT_SW_WI: state_q <= S_SRT_SW_WJ;
        S_SRT_SW_WJ: begin
          i_q     <= i_q + 8'sd1;
          j_q     <= j_q - 8'sd1;
          state_q <= S_SRT_LOOP;
        end
        S_SRT_PUSH_A: begin
          if (i_lt_hi && sp_room) begin
            sp_q <= sp_q + CW'(1);
          end
          state_q <= S_SRT_PUSH_B;
        end
        S_SRT_PUSH_B: begin
          if (lo_lt_j && sp_room) begin
            sp_q <= sp_q + CW'(1);
          end
          state_q <= S_SRT_POP;
        end

        // hold the word until taken; a dump walks on to the next entry
        S_WAIT: begin
          if (out_take) begin
            out_valid_q <= 1'b0;
            if (more_q) begin
              idx_q   <= idx_p1;
              state_q <= S_DMP_RD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// File: sv/slds_chk.sv
// ----------------------------------------------------------------------------
// slds_chk
// port-level checks on the record list unit, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slds_chk #(
  parameter int unsigned CAPACITY = slds_pkg::CAPACITY_DEF
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire slds_pkg::out_word_t out_word_o
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // no new word is taken while a result waits
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a result waits");

  // a taken word closes the input on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input still open after accept");

  // the entry total never exceeds the capacity
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.entry_total <= 7'(CAPACITY)))
    else $error("entry total beyond capacity");

  // a failed action gives a single final word
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status != slds_pkg::ST_OK) |-> out_word_o.last)
    else $error("error word not marked last");

endmodule

bind sequential_list_with_date_sort_unit slds_chk #(.CAPACITY(CAPACITY)) u_slds_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire

// File: tb/sequential_list_with_date_sort_unit_tb.sv
// ----------------------------------------------------------------------------
// sequential_list_with_date_sort_unit_tb
// drives list actions through the input channel, keeps its own copy of the
// record list, and compares every result word against it in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sequential_list_with_date_sort_unit_tb;

  localparam int CAP = 64;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  slds_pkg::in_word_t  in_word_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  slds_pkg::out_word_t out_word_o;

  sequential_list_with_date_sort_unit #(.CAPACITY(CAP)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always #10 clk_i = ~clk_i;

  // list copy, record key layout {year,month,day,id}
  logic [36:0]         rec_key [CAP];
  logic [31:0]         rec_pay [CAP];
  int                  rec_count;
  slds_pkg::out_word_t pending_words[$];
  int                  fail_count;
  bit                  quiet_phase;
  bit                  long_hold;

  function automatic logic [20:0] date_key(logic [36:0] k);
    return k[36:16];
  endfunction

  function automatic slds_pkg::out_word_t make_word(slds_pkg::status_e st, logic [36:0] k,
                                                    logic [31:0] p, int pos, bit lst);
    slds_pkg::out_word_t w;
    w.status       = st;
    w.out_id       = k[15:0];
    w.out_day      = k[20:16];
    w.out_month    = k[24:21];
    w.out_year     = k[36:25];
    w.out_payload  = p;
    w.out_position = pos[5:0];
    w.entry_total  = rec_count[6:0];
    w.last         = lst;
    return w;
  endfunction

  function automatic void swap_recs(int a, int b);
    logic [36:0] k;
    logic [31:0] p;
    k = rec_key[a]; p = rec_pay[a];
    rec_key[a] = rec_key[b]; rec_pay[a] = rec_pay[b];
    rec_key[b] = k; rec_pay[b] = p;
  endfunction

  // middle-pivot hoare quicksort with explicit range stack, same scan order as the block
  function automatic void date_sort();
    int lo_s[$], hi_s[$];
    int lo, hi, i, j;
    logic [20:0] pv;
    if (rec_count < 2) return;
    lo_s.push_back(0); hi_s.push_back(rec_count - 1);
    while (lo_s.size() > 0) begin
      lo = lo_s.pop_back(); hi = hi_s.pop_back();
      i = lo; j = hi;
      pv = date_key(rec_key[(lo + hi) / 2]);
      while (i <= j) begin
        while (i < hi && date_key(rec_key[i]) < pv) i++;
        while (j > lo && date_key(rec_key[j]) > pv) j--;
        if (i <= j) begin
          swap_recs(i, j);
          i++;
          j--;
        end
      end
      if (i < hi && lo_s.size() < 64) begin
        lo_s.push_back(i); hi_s.push_back(hi);
      end
      if (lo < j && lo_s.size() < 64) begin
        lo_s.push_back(lo); hi_s.push_back(j);
      end
    end
  endfunction

  function automatic slds_pkg::status_e list_insert(int pos, logic [36:0] k, logic [31:0] p);
    if (rec_count >= CAP) return slds_pkg::ST_FULL;
    if (pos > rec_count) return slds_pkg::ST_POS_RANGE;
    for (int i = rec_count; i > pos; i--) begin
      rec_key[i] = rec_key[i-1];
      rec_pay[i] = rec_pay[i-1];
    end
    rec_key[pos] = k; rec_pay[pos] = p;
    rec_count++;
    return slds_pkg::ST_OK;
  endfunction

  function automatic slds_pkg::status_e list_remove(int pos, output logic [36:0] k,
                                                    output logic [31:0] p);
    k = '0; p = '0;
    if (rec_count == 0) return slds_pkg::ST_EMPTY;
    if (pos >= rec_count) return slds_pkg::ST_POS_RANGE;
    k = rec_key[pos]; p = rec_pay[pos];
    rec_count--;
    for (int i = pos; i < rec_count; i++) begin
      rec_key[i] = rec_key[i+1];
      rec_pay[i] = rec_pay[i+1];
    end
    return slds_pkg::ST_OK;
  endfunction

  // works out the result words of one accepted action
  function automatic void predict_action(slds_pkg::in_word_t w);
    logic [36:0] k, rk;
    logic [31:0] rp;
    slds_pkg::status_e st;
    int found;
    k = {w.start_year, w.start_month, w.start_day, w.entry_id};
    rk = '0; rp = '0; st = slds_pkg::ST_OK;
    case (w.action)
      slds_pkg::ACT_INS_FRONT: st = list_insert(0, k, w.payload);
      slds_pkg::ACT_INS_BACK:  st = list_insert(rec_count, k, w.payload);
      slds_pkg::ACT_INS_AT:    st = list_insert(w.position, k, w.payload);
      slds_pkg::ACT_REM_FRONT: st = list_remove(0, rk, rp);
      slds_pkg::ACT_REM_BACK:  st = list_remove(rec_count == 0 ? 0 : rec_count - 1, rk, rp);
      slds_pkg::ACT_REM_AT:    st = list_remove(w.position, rk, rp);
      slds_pkg::ACT_SEARCH: begin
        found = -1;
        for (int i = 0; i < rec_count; i++)
          if (found < 0 && rec_key[i][15:0] == w.entry_id) found = i;
        if (found < 0)
          pending_words.push_back(make_word(slds_pkg::ST_NOT_FOUND, '0, '0, 0, 1'b1));
        else pending_words.push_back(make_word(slds_pkg::ST_OK, '0, '0, found, 1'b1));
        return;
      end
      slds_pkg::ACT_SORT: date_sort();
      slds_pkg::ACT_DUMP: begin
        if (rec_count == 0)
          pending_words.push_back(make_word(slds_pkg::ST_EMPTY, '0, '0, 0, 1'b1));
        for (int i = 0; i < rec_count; i++)
          pending_words.push_back(make_word(slds_pkg::ST_OK, rec_key[i], rec_pay[i], i,
                                            i + 1 == rec_count));
        return;
      end
      default: ;
    endcase
    pending_words.push_back(make_word(st, rk, rp, 0, 1'b1));
  endfunction

  // result checker
  always @(posedge clk_i) begin
    slds_pkg::out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result word %h", out_word_o);
      end else begin
        exp_w = pending_words.pop_front();
        if (out_word_o !== exp_w) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected %h actual %h", exp_w, out_word_o);
        end
      end
    end
  end

  // receiver stall: random bursts, one long hold, none in the quiet phase
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        out_stall_i <= 1'b0;
        long_hold = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 17);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // directed table; typed-in status only where it is obvious, else predictor checks
  slds_pkg::in_word_t dir_table[$];
  int                 dir_status[$];   // -1 means no typed-in status

  function automatic slds_pkg::in_word_t mk(slds_pkg::action_e a, int pos, int id, int d,
                                            int m, int y, int p);
    slds_pkg::in_word_t w;
    w.action = a; w.position = pos[6:0]; w.entry_id = id[15:0];
    w.start_day = d[4:0]; w.start_month = m[3:0]; w.start_year = y[11:0];
    w.payload = p;
    return w;
  endfunction

  task automatic send_word(slds_pkg::in_word_t w);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    predict_action(w);
  endtask

  task automatic sender_gap();
    int n;
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 17);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  function automatic slds_pkg::in_word_t rand_word(int bias);
    slds_pkg::in_word_t w;
    int a;
    w.payload  = $urandom;
    w.entry_id = 16'($urandom);
    a = $urandom_range(0, 99);
    if (a < bias) w.action = slds_pkg::action_e'($urandom_range(0, 2));
    else if (a < 85) w.action = slds_pkg::action_e'($urandom_range(3, 8));
    else if (a < 90) w.action = 4'($urandom_range(9, 15));
    else w.action = slds_pkg::action_e'($urandom_range(0, 8));
    w.position    = (a % 7 == 0) ? 7'($urandom_range(0, 127))
                                 : 7'($urandom_range(0, rec_count + 1));
    w.start_day   = 5'($urandom_range(0, 31));
    w.start_month = 4'($urandom_range(0, 15));
    w.start_year  = $urandom_range(0, 5) == 0 ? 12'($urandom) : 12'($urandom_range(2000, 2003));
    if ($urandom_range(0, 3) == 0) w.entry_id = 16'($urandom_range(0, 7));
    return w;
  endfunction

  initial begin
    slds_pkg::in_word_t w;
    int st_typed;
    rec_count = 0; fail_count = 0; quiet_phase = 0; long_hold = 0;
    dir_table.push_back(mk(slds_pkg::ACT_REM_FRONT, 0, 0, 0, 0, 0, 0));
    dir_status.push_back(slds_pkg::ST_EMPTY);
    dir_table.push_back(mk(slds_pkg::ACT_REM_BACK, 0, 0, 0, 0, 0, 0));
    dir_status.push_back(slds_pkg::ST_EMPTY);
    dir_table.push_back(mk(slds_pkg::ACT_REM_AT, 127, 0, 0, 0, 0, 0));
    dir_status.push_back(slds_pkg::ST_EMPTY);
    dir_table.push_back(mk(slds_pkg::ACT_DUMP, 0, 0, 0, 0, 0, 0));
    dir_status.push_back(slds_pkg::ST_EMPTY);
    dir_table.push_back(mk(slds_pkg::ACT_SEARCH, 0, 5, 0, 0, 0, 0));
    dir_status.push_back(slds_pkg::ST_NOT_FOUND);
    dir_table.push_back(mk(slds_pkg::ACT_SORT, 0, 0, 0, 0, 0, 0));
    dir_status.push_back(slds_pkg::ST_OK);
    dir_table.push_back(mk(slds_pkg::ACT_INS_AT, 1, 1, 1, 1, 1, 1));
    dir_status.push_back(slds_pkg::ST_POS_RANGE);
    dir_table.push_back(mk(slds_pkg::ACT_INS_FRONT, 0, 16'hFFFF, 31, 15, 4095, -1));
    dir_status.push_back(slds_pkg::ST_OK);
    dir_table.push_back(mk(slds_pkg::ACT_INS_BACK, 0, 0, 0, 0, 0, 0));
    dir_status.push_back(slds_pkg::ST_OK);
    dir_table.push_back(mk(slds_pkg::ACT_INS_AT, 1, 7, 5, 3, 2001, 32'h5A5A5A5A));
    dir_status.push_back(-1);
    dir_table.push_back(mk(slds_pkg::ACT_INS_AT, 3, 7, 5, 3, 2001, 32'hA5A5A5A5));
    dir_status.push_back(-1);
    dir_table.push_back(mk(slds_pkg::ACT_INS_AT, 5, 9, 9, 9, 9, 9));
    dir_status.push_back(slds_pkg::ST_POS_RANGE);
    dir_table.push_back(mk(slds_pkg::ACT_SEARCH, 0, 7, 0, 0, 0, 0));
    dir_status.push_back(-1);
    dir_table.push_back(mk(slds_pkg::ACT_DUMP, 0, 0, 0, 0, 0, 0));
    dir_status.push_back(-1);
    dir_table.push_back(mk(slds_pkg::ACT_SORT, 0, 0, 0, 0, 0, 0));
    dir_status.push_back(-1);
    dir_table.push_back(mk(slds_pkg::ACT_DUMP, 0, 0, 0, 0, 0, 0));
    dir_status.push_back(-1);
    dir_table.push_back(mk(slds_pkg::ACT_REM_AT, 4, 0, 0, 0, 0, 0));
    dir_status.push_back(slds_pkg::ST_POS_RANGE);
    dir_table.push_back(mk(slds_pkg::ACT_REM_AT, 1, 0, 0, 0, 0, 0));
    dir_status.push_back(-1);
    dir_table.push_back(mk(slds_pkg::ACT_REM_BACK, 0, 0, 0, 0, 0, 0));
    dir_status.push_back(-1);
    dir_table.push_back(mk(slds_pkg::ACT_REM_FRONT, 0, 0, 0, 0, 0, 0));
    dir_status.push_back(-1);
    dir_table.push_back(slds_pkg::in_word_t'({4'd15, 103'd0}));
    dir_status.push_back(slds_pkg::ST_OK);
    dir_table.push_back(slds_pkg::in_word_t'({4'd9, 103'd0}));
    dir_status.push_back(slds_pkg::ST_OK);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[n]) begin
      st_typed = dir_status[n];
      send_word(dir_table[n]);
      // typed-in status sits on the word just queued
      if (st_typed >= 0 && pending_words[$].status != st_typed) begin
        fail_count++;
        if (fail_count <= 10)
          $display("row %0d: expected status %0d, predicted %0d", n, st_typed,
                   pending_words[$].status);
      end
      sender_gap();
    end
    wait_drained();

    // fill to capacity, then full-list inserts, a sort, a dump and removes, with the receiver held off a while
    long_hold = 1'b1;
    while (rec_count < CAP) begin
      w = rand_word(100);
      send_word(w);
    end
    send_word(mk(slds_pkg::ACT_INS_BACK, 0, 1, 1, 1, 1, 1));
    send_word(mk(slds_pkg::ACT_INS_AT, 127, 1, 1, 1, 1, 1));
    send_word(mk(slds_pkg::ACT_SORT, 0, 0, 0, 0, 0, 0));
    send_word(mk(slds_pkg::ACT_DUMP, 0, 0, 0, 0, 0, 0));
    send_word(mk(slds_pkg::ACT_REM_AT, 63, 0, 0, 0, 0, 0));
    send_word(mk(slds_pkg::ACT_REM_AT, 64, 0, 0, 0, 0, 0));
    wait_drained();

    for (int n = 0; n < 100; n++) begin
      if (n == 80) begin
        wait_drained();
        quiet_phase = 1'b1;
      end
      w = rand_word(rec_count < 8 ? 70 : (rec_count > 56 ? 20 : 45));
      send_word(w);
      sender_gap();
    end
    send_word(mk(slds_pkg::ACT_SORT, 0, 0, 0, 0, 0, 0));
    send_word(mk(slds_pkg::ACT_DUMP, 0, 0, 0, 0, 0, 0));
    wait_drained();
    repeat (200) @(posedge clk_i);

    if (fail_count == 0 && pending_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sequential_list_with_date_sort_unit.f
sv/slds_pkg.sv
sv/sequential_list_with_date_sort_unit.sv
sv/slds_chk.sv
tb/sequential_list_with_date_sort_unit_tb.sv
